// ----- sv/tste_pkg.sv -----
// Shared types and constants for the ternary symbol transition entropy block.
package tste_pkg;

  // log2(6) in Q16, rounded
  localparam logic [17:0] LOG2_6_Q16 = 18'd169408;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [16:0] H_MAX      = 17'd65536;
  localparam int          NUM_TRANS  = 6;

  // Symbol codes
  localparam logic [1:0] SYM_DOWN = 2'd0;
  localparam logic [1:0] SYM_FLAT = 2'd1;
  localparam logic [1:0] SYM_UP   = 2'd2;

  // Six transition counters, packed
  typedef logic [NUM_TRANS-1:0][15:0] cnt_vec_t;

  // One finished result
  typedef struct packed {
    logic [15:0] symbol_count;
    logic [16:0] entropy;
  } tste_res_t;

endpackage

// ----- sv/ternary_symbol_transition_entropy_core.sv -----
// Top level: symbol classifier, transition counters and result register.
//
//  channel  direction  handshake                    payload
//  s_axis   in         s_axis_tvalid/s_axis_tready  tdata sample, tlast end of series
//  m_axis   out        m_axis_tvalid/m_axis_tready  tdata entropy, symbol_count
//  cfg      in         cfg_valid/cfg_ready          cfg_data threshold
//
// Ordinary samples are accepted back to back while s_axis_tready is high. A sample
// with tlast starts the entropy sequencer: one log2 of n plus one per nonzero
// counter on the shared multiplier, then the divisor and the division; a series
// with fewer than two symbols skips these steps and gives entropy zero.
// s_axis_tready stays low until the result moves to the output register, where it
// waits; new samples are taken meanwhile.
// Reset clears the series state, the threshold and the output valid flag.
module ternary_symbol_transition_entropy_core
  import tste_pkg::*;
#(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [16:0] entropy, [32:17] symbol_count, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data        // [30:0] threshold
);

  localparam int SW = $clog2(MAX_SAMPLES + 1);

  logic [30:0]   threshold;
  logic [31:0]   previous_sample;
  logic [1:0]    previous_symbol;
  logic [SW-1:0] samples_seen;
  cnt_vec_t      counts;

  logic          acc;
  logic          seen_inc;
  logic [SW-1:0] seen_next;
  logic [32:0]   diff;
  logic [32:0]   eta;
  logic [1:0]    sym;
  logic [2:0]    tidx;
  cnt_vec_t      counts_next;
  logic [31:0]   n;

  logic          ent_busy, ent_valid, ent_ready;
  tste_res_t     ent_res;
  tste_res_t     out_res;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !ent_busy;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Classify the difference to the previous sample
  always_comb begin
    diff = {s_axis_tdata[31], s_axis_tdata} - {previous_sample[31], previous_sample};
    eta  = {2'b00, threshold};
    if ($signed(diff) < -$signed(eta)) begin
      sym = SYM_DOWN;
    end else if ($signed(diff) > $signed(eta)) begin
      sym = SYM_UP;
    end else begin
      sym = SYM_FLAT;
    end
    tidx = {previous_symbol, 1'b0} + ((sym > previous_symbol) ? 3'(sym - 2'd1) : 3'(sym));
  end

  assign seen_inc  = (samples_seen < SW'(MAX_SAMPLES));
  assign seen_next = samples_seen + SW'(seen_inc);
  assign n         = 32'(seen_next - SW'(1));

  // Counters including the current sample
  always_comb begin
    counts_next = counts;
    if (seen_inc && samples_seen >= SW'(2) && sym != previous_symbol &&
        tidx < 3'(NUM_TRANS) && counts[tidx] != COUNT_MAX) begin
      counts_next[tidx] = counts[tidx] + 16'd1;
    end
  end

  // Series state
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= '0;
      previous_sample <= '0;
      previous_symbol <= '0;
      samples_seen    <= '0;
      counts          <= '0;
    end else begin
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
      if (acc) begin
        if (s_axis_tlast) begin
          previous_sample <= '0;
          previous_symbol <= '0;
          samples_seen    <= '0;
          counts          <= '0;
        end else if (seen_inc) begin
          previous_sample <= s_axis_tdata;
          if (samples_seen >= SW'(1)) begin
            previous_symbol <= sym;
          end
          samples_seen <= seen_next;
          counts       <= counts_next;
        end
      end
    end
  end

  tste_ent u_ent (
    .clk      (clk),
    .rst      (rst),
    .start    (acc && s_axis_tlast),
    .n_in     (n),
    .counts_in(counts_next),
    .busy     (ent_busy),
    .res_valid(ent_valid),
    .res_ready(ent_ready),
    .res      (ent_res)
  );

  // Output register
  assign ent_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ent_ready) begin
      m_axis_tvalid <= ent_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_ready && ent_valid) begin
      out_res <= ent_res;
    end
  end

  assign m_axis_tdata = {7'd0, out_res.symbol_count, out_res.entropy};

endmodule

// ----- sv/tste_mul.sv -----
// Shared 32x32 multiplier with a registered product.
module tste_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

// ----- sv/tste_ent.sv -----
// Entropy sequencer: log2 by repeated squaring, term sum and long division.
module tste_ent
  import tste_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [31:0] n_in,
  input  cnt_vec_t  counts_in,
  output logic      busy,
  output logic      res_valid,
  input  logic      res_ready,
  output tste_res_t res
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NORM  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_SQW   = 4'd3;
  localparam logic [3:0] S_LDONE = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_PICK  = 4'd6;
  localparam logic [3:0] S_DMUL  = 4'd7;
  localparam logic [3:0] S_DW    = 4'd8;
  localparam logic [3:0] S_CHK   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]  state;
  logic [31:0] n;
  cnt_vec_t    cnt;
  logic [47:0] s;
  logic [31:0] m;
  logic [4:0]  k;
  logic [15:0] frac;
  logic [4:0]  step;
  logic [2:0]  idx;
  logic        for_n;
  logic [20:0] ln;
  logic [63:0] num;
  logic [63:0] dsh;
  logic [16:0] q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [20:0] lval;
  logic [32:0] msq;

  tste_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  assign lval = {k, frac};
  assign msq  = mul_p[63:31];

  // Multiplier operand select
  always_comb begin
    mul_a = m;
    mul_b = m;
    unique case (state)
      S_LDONE: begin
        mul_a = 32'(cnt[idx]);
        mul_b = 32'(ln - lval);
      end
      S_DMUL: begin
        mul_a = n;
        mul_b = 32'(LOG2_6_Q16);
      end
      default: ;
    endcase
  end

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            n     <= n_in;
            cnt   <= counts_in;
            s     <= '0;
            m     <= n_in;
            k     <= 5'd31;
            frac  <= '0;
            step  <= '0;
            idx   <= '0;
            for_n <= 1'b1;
            res.symbol_count <= n_in[15:0];
            if (n_in < 32'd2) begin
              res.entropy <= '0;
              state       <= S_DONE;
            end else begin
              state <= S_NORM;
            end
          end
        end
        // Shift the leading one up to bit 31
        S_NORM: begin
          if (m[31]) begin
            state <= S_SQ;
          end else begin
            m <= {m[30:0], 1'b0};
            k <= k - 5'd1;
          end
        end
        S_SQ: state <= S_SQW;
        // One fraction bit per squaring
        S_SQW: begin
          if (msq[32]) begin
            m    <= msq[32:1];
            frac <= {frac[14:0], 1'b1};
          end else begin
            m    <= msq[31:0];
            frac <= {frac[14:0], 1'b0};
          end
          step  <= step + 5'd1;
          state <= (step == 5'd15) ? S_LDONE : S_SQ;
        end
        S_LDONE: begin
          if (for_n) begin
            ln    <= lval;
            for_n <= 1'b0;
            state <= S_PICK;
          end else if (lval < ln) begin
            state <= S_ACC;
          end else begin
            idx   <= idx + 3'd1;
            state <= S_PICK;
          end
        end
        S_ACC: begin
          s     <= s + mul_p[47:0];
          idx   <= idx + 3'd1;
          state <= S_PICK;
        end
        // Next nonzero counter, or on to the divisor
        S_PICK: begin
          if (idx == 3'(NUM_TRANS)) begin
            state <= S_DMUL;
          end else if (cnt[idx] == 16'd0) begin
            idx <= idx + 3'd1;
          end else begin
            m     <= 32'(cnt[idx]);
            k     <= 5'd31;
            frac  <= '0;
            step  <= '0;
            state <= S_NORM;
          end
        end
        S_DMUL: state <= S_DW;
        S_DW: begin
          num   <= {s, 16'd0} + (mul_p >> 1);
          dsh   <= mul_p << 16;
          q     <= '0;
          step  <= '0;
          state <= S_CHK;
        end
        S_CHK: begin
          if (num >= (dsh << 1)) begin
            res.entropy <= H_MAX;
            state       <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        // Restoring division, one quotient bit per cycle
        S_DIV: begin
          if (num >= dsh) begin
            num <= num - dsh;
            q   <= {q[15:0], 1'b1};
          end else begin
            q   <= {q[15:0], 1'b0};
          end
          dsh  <= dsh >> 1;
          step <= step + 5'd1;
          if (step == 5'd16) begin
            state <= S_DONE;
            if (num >= dsh) begin
              res.entropy <= ({q[15:0], 1'b1} > H_MAX) ? H_MAX : {q[15:0], 1'b1};
            end else begin
              res.entropy <= ({q[15:0], 1'b0} > H_MAX) ? H_MAX : {q[15:0], 1'b0};
            end
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/tste_chk.sv -----
// Port-level checker for the entropy core, bound to the top level.
module tste_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Entropy never exceeds one
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[16:0] <= 17'd65536)
    else $error("entropy out of range");

  // Pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
    else $error("pad bits set");

  // End of series starts the computation and blocks input
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken during computation");

  // Reset empties the output
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind ternary_symbol_transition_entropy_core tste_chk u_tste_chk (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
